// ----- hdl/sgr_pkg.sv -----
package sgr_pkg;

  // Font geometry
  localparam int FONT_WIDTH  = 5;
  localparam int FONT_HEIGHT = 7;
  localparam int CELL_WIDTH  = FONT_WIDTH + 1;
  localparam int MAX_SCALE   = 9;
  localparam int MAX_CHARS   = 64;

  // Field widths
  localparam int CODE_W   = 8;
  localparam int SCALE_W  = 4;
  localparam int STRIDE_W = 12;
  localparam int OFF_W    = 18;
  localparam int MASK_W   = FONT_WIDTH * MAX_SCALE;
  localparam int ROW_W    = 3;
  localparam int GLYPH_W  = FONT_WIDTH * FONT_HEIGHT;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = STRIDE_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 2'd1;

  // Reset values of the registers
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 4'd1;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 12'd384;

  // Start command from the position logic to the row generator
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic [OFF_W-1:0]  base;
  } sgr_start_t;

  // Whole glyph, top row in the upper five bits
  function automatic logic [GLYPH_W-1:0] glyph_bits(input logic [6:0] code);
    logic [GLYPH_W-1:0] g;
    unique case (code)
      7'd45:  g = {5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
      7'd47:  g = {5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd0, 5'd0};
      7'd37:  g = {5'd17, 5'd2, 5'd4, 5'd8, 5'd17, 5'd0, 5'd0};
      7'd48:  g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      7'd49:  g = {5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      7'd50:  g = {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31};
      7'd51:  g = {5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30};
      7'd52:  g = {5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2};
      7'd53:  g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30};
      7'd54:  g = {5'd6, 5'd8, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      7'd55:  g = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8};
      7'd56:  g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      7'd57:  g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd2, 5'd12};
      7'd65:  g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      7'd67:  g = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      7'd70:  g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      7'd71:  g = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
      7'd72:  g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      7'd76:  g = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      7'd77:  g = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      7'd78:  g = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      7'd80:  g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      7'd82:  g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      7'd83:  g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30};
      7'd84:  g = {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
      7'd85:  g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      7'd97:  g = {5'd0, 5'd0, 5'd14, 5'd1, 5'd15, 5'd17, 5'd15};
      7'd99:  g = {5'd0, 5'd0, 5'd14, 5'd16, 5'd16, 5'd17, 5'd14};
      7'd101: g = {5'd0, 5'd0, 5'd14, 5'd17, 5'd31, 5'd16, 5'd14};
      7'd102: g = {5'd6, 5'd8, 5'd8, 5'd30, 5'd8, 5'd8, 5'd8};
      7'd109: g = {5'd0, 5'd0, 5'd26, 5'd21, 5'd21, 5'd21, 5'd21};
      7'd112: g = {5'd0, 5'd0, 5'd30, 5'd17, 5'd17, 5'd30, 5'd16};
      7'd114: g = {5'd0, 5'd0, 5'd22, 5'd25, 5'd16, 5'd16, 5'd16};
      7'd126: g = {5'd15, 5'd8, 5'd14, 5'd8, 5'd0, 5'd0, 5'd0};
      7'd127: g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd0, 5'd0, 5'd0};
      default: g = '0;
    endcase
    return g;
  endfunction

  // One glyph row; codes of 128 and above are blank
  function automatic logic [FONT_WIDTH-1:0] glyph_row(input logic [CODE_W-1:0] code,
                                                      input logic [ROW_W-1:0] row);
    logic [GLYPH_W-1:0] g;
    logic [FONT_WIDTH-1:0] r;
    g = glyph_bits(code[6:0]);
    r = '0;
    for (int i = 0; i < FONT_HEIGHT; i++) begin
      if (row == ROW_W'(i)) begin
        r = g[GLYPH_W-1-i*FONT_WIDTH -: FONT_WIDTH];
      end
    end
    if (code[CODE_W-1]) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

// ----- hdl/sgr_ram.sv -----
module sgr_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/sgr_row_gen.sv -----
module sgr_row_gen (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sgr_pkg::sgr_start_t                start,
  input  logic [sgr_pkg::SCALE_W-1:0]        scale,
  input  logic [sgr_pkg::STRIDE_W-1:0]       row_stride,
  output logic                               busy,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sgr_pkg::OFF_W-1:0]          out_row_offset,
  output logic [sgr_pkg::MASK_W-1:0]         out_pixel_mask,
  output logic                               out_last_row
);

  localparam int MASK_W = sgr_pkg::MASK_W;
  localparam int FW     = sgr_pkg::FONT_WIDTH;
  localparam int PW     = $clog2(MASK_W + 1);

  logic                        busy_r;
  logic [sgr_pkg::CODE_W-1:0]  code_r;
  logic [sgr_pkg::ROW_W-1:0]   row_r;
  logic [sgr_pkg::SCALE_W-1:0] sub_r;
  logic [sgr_pkg::OFF_W-1:0]   off_r;
  logic                        out_valid_r;
  logic [sgr_pkg::OFF_W-1:0]   out_row_offset_r;
  logic [MASK_W-1:0]           out_pixel_mask_r;
  logic                        out_last_row_r;

  logic                        adv;
  logic                        sub_end;
  logic                        last;
  logic [FW-1:0]               bits;
  logic [MASK_W-1:0]           ones;
  logic [MASK_W-1:0]           mask;
  logic [PW-1:0]               lsb;

  // Widen the glyph row: each set column becomes a run of scale bits
  always_comb begin
    bits = sgr_pkg::glyph_row(code_r, row_r);
    ones = (MASK_W'(1) << scale) - MASK_W'(1);
    mask = '0;
    lsb  = '0;
    for (int x = 0; x < FW; x++) begin
      lsb = PW'(MASK_W) - PW'(x + 1) * PW'(scale);
      if (bits[FW-1-x]) begin
        mask = mask | (ones << lsb);
      end
    end
  end

  assign adv     = busy_r && (!out_valid_r || !out_stall);
  assign sub_end = (sub_r == scale - sgr_pkg::SCALE_W'(1));
  assign last    = sub_end && (row_r == sgr_pkg::ROW_W'(sgr_pkg::FONT_HEIGHT - 1));

  // Sequence rows of the current cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start.valid) begin
      busy_r <= 1'b1;
    end else if (adv && last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start.valid) begin
      code_r <= start.code;
      row_r  <= '0;
      sub_r  <= '0;
      off_r  <= start.base;
    end else if (adv) begin
      off_r <= off_r + sgr_pkg::OFF_W'(row_stride);
      if (sub_end) begin
        sub_r <= '0;
        row_r <= row_r + sgr_pkg::ROW_W'(1);
      end else begin
        sub_r <= sub_r + sgr_pkg::SCALE_W'(1);
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_row_offset_r <= off_r;
      out_pixel_mask_r <= mask;
      out_last_row_r   <= last;
    end
  end

  assign busy           = busy_r;
  assign out_valid      = out_valid_r;
  assign out_row_offset = out_row_offset_r;
  assign out_pixel_mask = out_pixel_mask_r;
  assign out_last_row   = out_last_row_r;

endmodule

// ----- hdl/scaled_glyph_rasterizer_unit.sv -----
// Scaled 5x7 character renderer.
// Input channel (in_valid/in_stall/in_char_code): one character byte per word.
// A zero byte ends the string and returns the cell position to the left edge.
// Result channel (out_valid/out_stall/...): for each rendered character,
// 7*scale words, top row first; each gives the buffer offset of the scaled
// row and a 45-bit pixel mask, leftmost pixel in bit 44, with out_last_row
// on the final word. Characters past MAX_CHARS, and all characters while
// scale is 0, above 9, or row_stride is under 6*scale, produce no words.
// Configuration port (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is
// scale, index 1 is row_stride; write only while the block is idle.
// Timing: a character is accepted, the cell position is read from the
// state RAM the next cycle, and rows then leave at one per cycle while
// out_stall is low. The input stays stalled until the row generator is
// done with the character. The output register lets the next
// character be taken while the last row still waits on out_stall.
// Reset: scale 1, row_stride 384; after reset the ST_CLEAR state clears
// the stored position, during which in_stall is high.
module scaled_glyph_rasterizer_unit #(
  parameter int MAX_CHARS = sgr_pkg::MAX_CHARS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sgr_pkg::CODE_W-1:0]         in_char_code,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sgr_pkg::OFF_W-1:0]          out_row_offset,
  output logic [sgr_pkg::MASK_W-1:0]         out_pixel_mask,
  output logic                               out_last_row,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sgr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int POS_W = $clog2(MAX_CHARS + 1);
  localparam int CW_W  = $clog2(sgr_pkg::CELL_WIDTH * sgr_pkg::MAX_SCALE + 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t                         state_r, state_nxt;
  logic [sgr_pkg::SCALE_W-1:0]    scale_r;
  logic [sgr_pkg::STRIDE_W-1:0]   stride_r;
  logic [sgr_pkg::CODE_W-1:0]     code_r;

  logic                           in_acc;
  logic                           ram_we;
  logic [POS_W-1:0]               ram_wdata;
  logic [POS_W-1:0]               pos_rd;
  logic                           gen_busy;
  logic                           enabled;
  logic [CW_W-1:0]                cell_w;
  sgr_pkg::sgr_start_t            start;

  assign in_stall  = !((state_r == ST_IDLE) && !gen_busy);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers; drop writes to unused indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= sgr_pkg::SCALE_RST;
      stride_r <= sgr_pkg::STRIDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sgr_pkg::REG_SCALE: begin
          scale_r <= cfg_data[sgr_pkg::SCALE_W-1:0];
        end
        sgr_pkg::REG_STRIDE: begin
          stride_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the accepted character
  always_ff @(posedge clk) begin
    if (in_acc) begin
      code_r <= in_char_code;
    end
  end

  assign cell_w  = CW_W'(sgr_pkg::CELL_WIDTH) * CW_W'(scale_r);
  assign enabled = (scale_r != '0) &&
                   (scale_r <= sgr_pkg::SCALE_W'(sgr_pkg::MAX_SCALE)) &&
                   (stride_r >= sgr_pkg::STRIDE_W'(cell_w));

  // Position update and row generator launch
  always_comb begin
    state_nxt   = state_r;
    ram_we      = 1'b0;
    ram_wdata   = pos_rd;
    start.valid = 1'b0;
    start.code  = code_r;
    start.base  = sgr_pkg::OFF_W'(pos_rd) * sgr_pkg::OFF_W'(cell_w);
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        ram_we    = 1'b1;
        state_nxt = ST_IDLE;
        priority if (code_r == '0) begin
          ram_wdata = '0;
        end else if (pos_rd >= POS_W'(MAX_CHARS)) begin
          ram_wdata = POS_W'(MAX_CHARS);
        end else begin
          ram_wdata   = pos_rd + POS_W'(1);
          start.valid = enabled;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Cell position store
  sgr_ram #(
    .DATA_W (POS_W),
    .DEPTH  (1)
  ) u_pos_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (1'b0),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (1'b0),
    .rdata (pos_rd)
  );

  // Scaled row generator
  sgr_row_gen u_row_gen (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .scale          (scale_r),
    .row_stride     (stride_r),
    .busy           (gen_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_offset (out_row_offset),
    .out_pixel_mask (out_pixel_mask),
    .out_last_row   (out_last_row)
  );

endmodule
